FILE: rtl/outstanding_work_tracker_top_assert.svh
// Assertion helpers shared by the tracker modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef OUTSTANDING_WORK_TRACKER_TOP_ASSERT_SVH
`define OUTSTANDING_WORK_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define OWT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/owt_pkg.sv
`default_nettype none
package owt_pkg;

  localparam int REQ_W   = 3;
  localparam int FIELD_W = 16;
  localparam int ID_W    = 2 * FIELD_W;
  localparam int LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // Request codes; codes 6 and 7 are unused and do nothing.
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FETCH  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REPORT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

  // Controller to datapath.
  typedef struct packed {
    logic cfg_wr;   // take a new entry limit, empty the table
    logic accept;   // capture the request, issue the first table read
    logic scan;     // process one table entry
    logic emit;     // move the result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic fin;      // request completes in this scan cycle
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/owt_ctrl.sv
`default_nettype none
module owt_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  owt_pkg::sts_t     sts_i,
  output owt_pkg::cmd_t     cmd_o
);
  import owt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_e;

  state_e state_q, state_d;
  logic   in_stall_q, in_stall_d;
  logic   cfg_ready_q, cfg_ready_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.cfg_wr = cfg_valid_i && cfg_ready_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.fin) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    in_stall_d  = (state_d != ST_IDLE);
    cfg_ready_d = (state_d == ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_stall_q  <= 1'b0;
      cfg_ready_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_stall_q  <= in_stall_d;
      cfg_ready_q <= cfg_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = in_stall_q;
  assign cfg_ready_o = cfg_ready_q;
  assign out_valid_o = out_valid_q;

`include "outstanding_work_tracker_top_assert.svh"

  `OWT_ASSERT_NEXT(a_accept_to_scan, cmd_o.accept, state_q == ST_SCAN, "accept did not start a scan")
  `OWT_ASSERT_IMPL(a_busy_no_cfg, state_q != ST_IDLE, !cfg_ready_o && in_stall_o, "busy but open to transfers")
  `OWT_ASSERT_NEXT(a_emit_valid, cmd_o.emit, out_valid_o, "emitted result not presented")

endmodule
`default_nettype wire

FILE: rtl/owt_dp.sv
`default_nettype none
module owt_dp #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  owt_pkg::cmd_t                        cmd_i,
  output owt_pkg::sts_t                        sts_o,
  input  wire logic [owt_pkg::LIMIT_W-1:0]     cfg_entry_limit_i,
  input  wire logic [owt_pkg::REQ_W-1:0]       req_type_i,
  input  wire logic [owt_pkg::FIELD_W-1:0]     player_i,
  input  wire logic [owt_pkg::FIELD_W-1:0]     work_code_i,
  output logic                                 ok_o,
  output logic [owt_pkg::FIELD_W-1:0]          found_player_o,
  output logic [owt_pkg::FIELD_W-1:0]          found_code_o
);
  import owt_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);       // table index
  localparam int CW = $clog2(MAX_ENTRIES + 1);   // entry count
  localparam int SW = CW + 1;                    // slot pool, up to twice the count

  // table: done flag above the 32-bit ID
  logic [ID_W:0]    mem_q [MAX_ENTRIES];
  logic [ID_W:0]    rd_q;
  logic [IW-1:0]    rd_addr;
  logic             we;
  logic [IW-1:0]    wa;
  logic [ID_W:0]    wd;

  logic [LIMIT_W-1:0] limit_q, limit_d;
  logic [CW-1:0]    count_q, count_d;
  logic [IW-1:0]    cursor_q, cursor_d;
  logic [SW-1:0]    slots_q, slots_d;

  logic [REQ_W-1:0] req_q, req_d;
  logic [ID_W-1:0]  id_q, id_d;
  logic [CW-1:0]    n_q, n_d;
  logic [CW-1:0]    r_q, r_d;
  logic [CW-1:0]    w_q, w_d;
  logic [SW-1:0]    rel_q, rel_d;
  logic             res_ok_q, res_ok_d;
  logic [ID_W-1:0]  res_fid_q, res_fid_d;
  logic             out_ok_q;
  logic [ID_W-1:0]  out_fid_q;

  logic [CW-1:0]    lim;
  logic [SW-1:0]    pool;
  logic [CW-1:0]    r_inc;
  logic             ent_valid;
  logic             ent_last;
  logic             ent_match;
  logic             ent_done;
  logic [CW-1:0]    cur_ext;
  logic [CW-1:0]    cur_inc;
  logic [IW-1:0]    cur_back;
  logic [SW-1:0]    rel_nx;
  logic             fin;

  always_comb begin
    if (limit_q == '0) begin
      lim = CW'(1);
    end else if (int'(limit_q) > MAX_ENTRIES) begin
      lim = CW'(MAX_ENTRIES);
    end else begin
      lim = CW'(limit_q);
    end
  end

  assign pool      = {lim, 1'b0};
  assign r_inc     = r_q + 1'b1;
  assign ent_valid = (r_q < n_q);
  assign ent_last  = (r_inc == n_q);
  assign ent_match = (rd_q[ID_W-1:0] == id_q);
  assign ent_done  = rd_q[ID_W];
  assign cur_ext   = CW'(cursor_q);
  assign cur_inc   = cur_ext + 1'b1;
  // step the cursor back for a removal at or below it, never below zero
  assign cur_back  = ((w_q <= cur_ext) && (cursor_q != '0)) ? cursor_q - 1'b1 : cursor_q;
  assign rel_nx    = rel_q + (ent_valid ? SW'(1) + SW'(ent_done) : '0);

  assign rd_addr = cmd_i.accept ? ((req_type_i == REQ_FETCH) ? cursor_q : '0)
                                : r_inc[IW-1:0];

  always_comb begin
    limit_d   = limit_q;
    count_d   = count_q;
    cursor_d  = cursor_q;
    slots_d   = slots_q;
    req_d     = req_q;
    id_d      = id_q;
    n_d       = n_q;
    r_d       = r_q;
    w_d       = w_q;
    rel_d     = rel_q;
    res_ok_d  = res_ok_q;
    res_fid_d = res_fid_q;
    we        = 1'b0;
    wa        = '0;
    wd        = '0;
    fin       = 1'b0;

    if (cmd_i.accept) begin
      req_d     = req_type_i;
      id_d      = {work_code_i, player_i};
      n_d       = count_q;
      r_d       = '0;
      w_d       = '0;
      rel_d     = '0;
      res_ok_d  = 1'b0;
      res_fid_d = '0;
    end else if (cmd_i.scan) begin
      r_d = r_inc;
      case (req_q)
        REQ_ADD: begin
          fin = 1'b1;
          if ((count_q < lim) && (slots_q < pool)) begin
            we       = 1'b1;
            wa       = count_q[IW-1:0];
            wd       = {1'b0, id_q};
            count_d  = count_q + 1'b1;
            slots_d  = slots_q + 1'b1;
            res_ok_d = 1'b1;
          end
        end
        REQ_FETCH: begin
          fin = 1'b1;
          if ((count_q != '0) && (cur_ext < count_q) && !ent_done) begin
            res_ok_d  = 1'b1;
            res_fid_d = rd_q[ID_W-1:0];
            cursor_d  = (cur_inc == count_q) ? '0 : cur_inc[IW-1:0];
          end
        end
        REQ_REPORT: begin
          res_ok_d = 1'b1;
          if (!ent_valid) begin
            fin = 1'b1;
          end else if (ent_match) begin
            if (slots_q >= pool) begin
              fin = 1'b1;
            end else begin
              slots_d = slots_q + 1'b1;
              we      = 1'b1;
              wa      = r_q[IW-1:0];
              wd      = {1'b1, rd_q[ID_W-1:0]};
              fin     = ent_last;
            end
          end else begin
            fin = ent_last;
          end
        end
        REQ_QUERY: begin
          if (!ent_valid) begin
            fin = 1'b1;
          end else if (ent_match) begin
            res_ok_d = ent_done;
            fin      = 1'b1;
          end else begin
            fin = ent_last;
          end
        end
        REQ_DELETE: begin
          // compact in place: survivors move down to the write pointer
          if (!ent_valid) begin
            fin = 1'b1;
          end else if (ent_match) begin
            count_d  = count_q - 1'b1;
            cursor_d = (CW'(cur_back) == count_d) ? '0 : cur_back;
            fin      = ent_last;
          end else begin
            we  = 1'b1;
            wa  = w_q[IW-1:0];
            wd  = rd_q;
            w_d = w_q + 1'b1;
            fin = ent_last;
          end
        end
        REQ_CLEAR: begin
          rel_d = rel_nx;
          fin   = !ent_valid || ent_last;
          if (fin) begin
            slots_d  = (rel_nx >= slots_q) ? '0 : slots_q - rel_nx;
            count_d  = '0;
            cursor_d = '0;
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end

    if (cmd_i.cfg_wr) begin
      limit_d  = cfg_entry_limit_i;
      count_d  = '0;
      cursor_d = '0;
      slots_d  = '0;
    end
  end

  assign sts_o.fin = fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RESET;
      count_q  <= '0;
      cursor_q <= '0;
      slots_q  <= '0;
    end else begin
      limit_q  <= limit_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      slots_q  <= slots_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    id_q      <= id_d;
    n_q       <= n_d;
    r_q       <= r_d;
    w_q       <= w_d;
    rel_q     <= rel_d;
    res_ok_q  <= res_ok_d;
    res_fid_q <= res_fid_d;
    if (cmd_i.emit) begin
      out_ok_q  <= res_ok_q;
      out_fid_q <= res_fid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign ok_o           = out_ok_q;
  assign found_player_o = out_fid_q[FIELD_W-1:0];
  assign found_code_o   = out_fid_q[ID_W-1:FIELD_W];

`include "outstanding_work_tracker_top_assert.svh"

  `OWT_ASSERT_IMPL(a_count_in_limit, 1'b1, count_q <= lim, "entry count above limit")
  `OWT_ASSERT_IMPL(a_cursor_in_table, 1'b1, (cursor_q == '0) || (cur_ext < count_q), "cursor off table")
  `OWT_ASSERT_IMPL(a_slots_in_pool, 1'b1, slots_q <= pool, "slot pool overrun")

endmodule
`default_nettype wire

FILE: rtl/outstanding_work_tracker_top.sv
`default_nettype none
// Channel   Dir  Handshake             Payload
// in        in   in_valid_i/in_stall_o  req_type_i, player_i, work_code_i
// out       out  out_valid_o/out_stall_i ok_o, found_player_o, found_code_o
// cfg       in   cfg_valid_i/cfg_ready_o cfg_entry_limit_i
//
// Add, fetch and unused codes finish on their first scan step; report, query, delete
// and clear scan at least one and at most MAX_ENTRIES entries, since the table gives
// up one entry a cycle. One request at a time.
// Reset (rst_ni low, asynchronous) empties the table, zeroes cursor and slot pool and
// loads an entry limit of 16. A stalled output holds its result; the next request is
// still taken and waits in its final cycle until the output register frees up.
module outstanding_work_tracker_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // request channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [owt_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [owt_pkg::FIELD_W-1:0]  player_i,
  input  wire logic [owt_pkg::FIELD_W-1:0]  work_code_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              ok_o,
  output logic [owt_pkg::FIELD_W-1:0]       found_player_o,
  output logic [owt_pkg::FIELD_W-1:0]       found_code_o,
  // entry limit register
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [owt_pkg::LIMIT_W-1:0]  cfg_entry_limit_i
);
  import owt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: idle -> scan (one table entry per cycle) -> emit.
  owt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Table memory, counters, per-request scan logic and the output register.
  // Delete compacts the table in one pass with separate read and write pointers.
  owt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_entry_limit_i (cfg_entry_limit_i),
    .req_type_i        (req_type_i),
    .player_i          (player_i),
    .work_code_i       (work_code_i),
    .ok_o              (ok_o),
    .found_player_o    (found_player_o),
    .found_code_o      (found_code_o)
  );

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import owt_pkg::*;

  localparam int MAX_ENTRIES = 16;
  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 9;
  // Hard stop for a hung run, several times the slowest legal run.
  localparam int LIMIT_CYCLES = 800000;
  // Longest request is a full table scan plus capture and emit.
  localparam int DRAIN_CYCLES = MAX_ENTRIES + 6;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 190;
  localparam int ID_POOL_SIZE = 6;

  // Request codes the block does not decode; they must answer all zeros.
  localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic               ok;
    logic [FIELD_W-1:0] player;
    logic [FIELD_W-1:0] code;
  } reply_t;

  localparam reply_t R_NONE = '{1'b0, 16'h0000, 16'h0000};
  localparam reply_t R_OK = '{1'b1, 16'h0000, 16'h0000};
  localparam reply_t R_TOP = '{1'b1, 16'hFFFF, 16'hFFFF};

  // Directed rows: write the limit, send with a predicted reply, or send with
  // a reply that is typed into the row.
  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [LIMIT_W-1:0] limit;
    logic [REQ_W-1:0]   req;
    logic [FIELD_W-1:0] pl;
    logic [FIELD_W-1:0] wc;
    reply_t             want;
  } step_t;

  localparam int PLAN_LEN = 27;

  step_t plan [PLAN_LEN] = '{
    // Empty table right after reset: fetch and query both miss.
    '{ROW_TYPED,   5'd0,  REQ_FETCH,    16'h0000, 16'h0000, R_NONE},
    '{ROW_TYPED,   5'd0,  REQ_QUERY,    16'h1234, 16'hABCD, R_NONE},
    // All-ones and all-zeros IDs, then a duplicate next to its twin.
    '{ROW_TYPED,   5'd0,  REQ_ADD,      16'hFFFF, 16'hFFFF, R_OK},
    '{ROW_TYPED,   5'd0,  REQ_ADD,      16'h0000, 16'h0000, R_OK},
    '{ROW_TYPED,   5'd0,  REQ_ADD,      16'h0000, 16'h0000, R_OK},
    '{ROW_TYPED,   5'd0,  REQ_ADD,      16'h5555, 16'hAAAA, R_OK},
    '{ROW_TYPED,   5'd0,  REQ_FETCH,    16'h0000, 16'h0000, R_TOP},
    '{ROW_TYPED,   5'd0,  REQ_FETCH,    16'h0000, 16'h0000, R_OK},
    // Report twice: the second one hits an entry that is already done.
    '{ROW_TYPED,   5'd0,  REQ_REPORT,   16'hFFFF, 16'hFFFF, R_OK},
    '{ROW_TYPED,   5'd0,  REQ_REPORT,   16'hFFFF, 16'hFFFF, R_OK},
    '{ROW_TYPED,   5'd0,  REQ_QUERY,    16'hFFFF, 16'hFFFF, R_OK},
    // Delete both adjacent twins, then fetch at a done entry.
    '{ROW_PREDICT, 5'd0,  REQ_DELETE,   16'h0000, 16'h0000, R_NONE},
    '{ROW_PREDICT, 5'd0,  REQ_FETCH,    16'h0000, 16'h0000, R_NONE},
    '{ROW_TYPED,   5'd0,  REQ_UNUSED_6, 16'hFFFF, 16'hFFFF, R_NONE},
    '{ROW_TYPED,   5'd0,  REQ_CLEAR,    16'h0000, 16'h0000, R_NONE},
    // Limit of one: full table, exhausted pool, report past the pool.
    '{ROW_CFG,     5'd1,  REQ_ADD,      16'h0000, 16'h0000, R_NONE},
    '{ROW_TYPED,   5'd0,  REQ_ADD,      16'h1111, 16'h2222, R_OK},
    '{ROW_TYPED,   5'd0,  REQ_ADD,      16'h3333, 16'h4444, R_NONE},
    '{ROW_TYPED,   5'd0,  REQ_REPORT,   16'h1111, 16'h2222, R_OK},
    '{ROW_TYPED,   5'd0,  REQ_REPORT,   16'h1111, 16'h2222, R_OK},
    '{ROW_TYPED,   5'd0,  REQ_QUERY,    16'h1111, 16'h2222, R_OK},
    '{ROW_PREDICT, 5'd0,  REQ_DELETE,   16'h1111, 16'h2222, R_NONE},
    '{ROW_TYPED,   5'd0,  REQ_ADD,      16'h3333, 16'h4444, R_NONE},
    '{ROW_PREDICT, 5'd0,  REQ_CLEAR,    16'h0000, 16'h0000, R_NONE},
    // A limit of zero clamps up to one.
    '{ROW_CFG,     5'd0,  REQ_ADD,      16'h0000, 16'h0000, R_NONE},
    '{ROW_TYPED,   5'd0,  REQ_ADD,      16'h0001, 16'h8000, R_OK},
    '{ROW_TYPED,   5'd0,  REQ_ADD,      16'h0002, 16'h0000, R_NONE}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [REQ_W-1:0] req_type_i = REQ_ADD;
  logic [FIELD_W-1:0] player_i = '0;
  logic [FIELD_W-1:0] work_code_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic ok_o;
  logic [FIELD_W-1:0] found_player_o;
  logic [FIELD_W-1:0] found_code_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [LIMIT_W-1:0] cfg_entry_limit_i = '0;

  // Shadow of the tracker: table, cursor, slot pool and the limit register.
  logic [ID_W-1:0] tbl_id [MAX_ENTRIES];
  logic tbl_done [MAX_ENTRIES];
  int unsigned tbl_count;
  int unsigned tbl_cursor;
  int unsigned slots_taken;
  logic [LIMIT_W-1:0] limit_reg;

  // Replies owed by the block, oldest first.
  reply_t awaited [$];
  int mismatches = 0;
  // Remaining length of a no-idle stretch on each side.
  int send_calm = 0;
  int recv_calm = 0;

  outstanding_work_tracker_top #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .player_i         (player_i),
    .work_code_i      (work_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .ok_o             (ok_o),
    .found_player_o   (found_player_o),
    .found_code_o     (found_code_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_entry_limit_i(cfg_entry_limit_i)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // A new limit re-creates the tracker: empty table, cursor and pool at zero.
  function automatic void load_limit(input logic [LIMIT_W-1:0] lim);
    limit_reg = lim;
    tbl_count = 0;
    tbl_cursor = 0;
    slots_taken = 0;
  endfunction

  // Advance the shadow by one request and return the reply it must give.
  function automatic reply_t apply_request(input logic [REQ_W-1:0] req,
                                           input logic [FIELD_W-1:0] pl,
                                           input logic [FIELD_W-1:0] wc);
    reply_t r;
    logic [ID_W-1:0] id;
    int unsigned lim;
    int unsigned pool;
    int unsigned i;
    int unsigned j;
    int unsigned rel;
    r = R_NONE;
    id = {wc, pl};
    // Clamp the limit into 1..MAX_ENTRIES; the pool holds twice that.
    lim = limit_reg;
    if (lim < 1) lim = 1;
    if (lim > MAX_ENTRIES) lim = MAX_ENTRIES;
    pool = 2 * lim;
    if (tbl_count > lim) tbl_count = lim;
    case (req)
      REQ_ADD: begin
        if (tbl_count < lim && slots_taken < pool) begin
          tbl_id[tbl_count] = id;
          tbl_done[tbl_count] = 1'b0;
          tbl_count++;
          slots_taken++;
          r.ok = 1'b1;
        end
      end
      REQ_FETCH: begin
        // A done entry under the cursor blocks the fetch; the cursor holds.
        if (tbl_count != 0 && tbl_cursor < tbl_count && !tbl_done[tbl_cursor]) begin
          {r.code, r.player} = tbl_id[tbl_cursor];
          tbl_cursor++;
          if (tbl_cursor == tbl_count) tbl_cursor = 0;
          r.ok = 1'b1;
        end
      end
      REQ_REPORT: begin
        // Each match costs a slot; stop marking once the pool runs dry.
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_id[i] == id) begin
            if (slots_taken >= pool) break;
            slots_taken++;
            tbl_done[i] = 1'b1;
          end
        end
        r.ok = 1'b1;
      end
      REQ_QUERY: begin
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_id[i] == id) begin
            r.ok = tbl_done[i];
            break;
          end
        end
      end
      REQ_DELETE: begin
        // Re-check the same index after a shift: the moved entry may match.
        i = 0;
        while (i < tbl_count) begin
          if (tbl_id[i] == id) begin
            for (j = i; j + 1 < tbl_count; j++) begin
              tbl_id[j] = tbl_id[j + 1];
              tbl_done[j] = tbl_done[j + 1];
            end
            tbl_count--;
            if (i <= tbl_cursor && tbl_cursor > 0) tbl_cursor--;
            if (tbl_cursor == tbl_count) tbl_cursor = 0;
          end else begin
            i++;
          end
        end
      end
      REQ_CLEAR: begin
        // Give back one slot per entry and one more per done entry.
        rel = tbl_count;
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_done[i]) rel++;
        end
        slots_taken = (rel >= slots_taken) ? 0 : slots_taken - rel;
        tbl_count = 0;
        tbl_cursor = 0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Wait per transfer, with occasional stretches of back-to-back traffic.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm_left = $urandom_range(16, 64);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Present one request, hold it until the transfer, then book its reply.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [FIELD_W-1:0] pl,
                              input logic [FIELD_W-1:0] wc, input bit typed,
                              input reply_t want);
    reply_t r;
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    player_i <= pl;
    work_code_i <= wc;
    do @(posedge clk_i); while (in_stall_o);
    r = apply_request(req, pl, wc);
    awaited.push_back(typed ? want : r);
  endtask

  // Drop valid, wait out every owed reply, then let the block go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the limit only with the block idle.
  task automatic write_limit(input logic [LIMIT_W-1:0] lim);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_entry_limit_i <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    load_limit(lim);
  endtask

  // Stimulus: reset, directed table, then random phases under varied limits.
  initial begin
    logic [ID_W-1:0] id_pool [ID_POOL_SIZE];
    logic [ID_W-1:0] id;
    logic [REQ_W-1:0] req;
    logic [LIMIT_W-1:0] lim;
    int k;
    int phase;
    int n;
    int pick;
    int clear_pct;
    load_limit(LIMIT_RESET);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < PLAN_LEN; k++) begin
      if (plan[k].kind == ROW_CFG) begin
        write_limit(plan[k].limit);
      end else begin
        send_request(plan[k].req, plan[k].pl, plan[k].wc, plan[k].kind == ROW_TYPED,
                     plan[k].want);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      // Hit the legal extremes and both clamped sides, then random limits.
      case (phase)
        0: lim = 5'd16;
        1: lim = 5'd1;
        2: lim = 5'd2;
        3: lim = 5'd31;
        4: lim = 5'd0;
        5: lim = 5'd17;
        6: lim = 5'd4;
        7: lim = 5'd8;
        default: lim = LIMIT_W'($urandom_range(0, 31));
      endcase
      write_limit(lim);

      // A few IDs per phase so requests keep hitting live entries; two of
      // them differ from another in one half only.
      for (k = 0; k < ID_POOL_SIZE; k++) id_pool[k] = $urandom;
      id_pool[4] = {~id_pool[0][ID_W-1:FIELD_W], id_pool[0][FIELD_W-1:0]};
      id_pool[5] = {id_pool[1][ID_W-1:FIELD_W], id_pool[1][FIELD_W-1:0] ^ 16'h8000};
      // Rare clears in some phases let the table fill up.
      clear_pct = (phase % 3 == 0) ? 1 : 6;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) req = REQ_ADD;
        else if (pick < 52) req = REQ_FETCH;
        else if (pick < 64) req = REQ_REPORT;
        else if (pick < 76) req = REQ_QUERY;
        else if (pick < 86) req = REQ_DELETE;
        else if (pick < 86 + clear_pct) req = REQ_CLEAR;
        else if (pick < 89 + clear_pct) req = $urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
        else req = REQ_ADD;
        id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, ID_POOL_SIZE - 1)]
                                           : $urandom;
        send_request(req, id[FIELD_W-1:0], id[ID_W-1:FIELD_W], 1'b0, R_NONE);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Reply side: stall at random, then take the next transfer and compare it
  // with the oldest owed reply.
  initial begin
    reply_t want;
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = draw_wait(recv_calm);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (awaited.size() == 0) begin
        $error("reply with nothing owed: ok %0d player %h code %h", ok_o, found_player_o,
               found_code_o);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        if (ok_o !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, ok_o);
          mismatches++;
        end
        if (found_player_o !== want.player) begin
          $error("found_player: expected %h, got %h", want.player, found_player_o);
          mismatches++;
        end
        if (found_code_o !== want.code) begin
          $error("found_code: expected %h, got %h", want.code, found_code_o);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAILURE");
    $finish;
  end

endmodule
